// ===== hdl/bsm_pkg.sv =====
`default_nettype none
package bsm_pkg;

   // frame limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
   localparam int WREG_W     = 11;
   localparam int HREG_W     = 13;
   localparam int LAG_W      = $clog2(2 * MAX_WIDTH + 3);
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 4'd1;

   // item kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // reset register values
   localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;

   // reciprocal of six, scaled by 2^18
   localparam logic [15:0] RECIP6       = 16'd43691;
   localparam int          RECIP6_SHIFT = 18;

   typedef struct packed {
      logic       req_type;
      logic [7:0] pixel;
   } req_type_type;

   typedef struct packed {
      logic [7:0] magnitude;
      logic       last_of_frame;
   } rsp_type;

   // work for the back end, one per stream step
   typedef struct packed {
      logic             is_pix;
      logic [7:0]       pixel;
      logic [COL_W-1:0] in_col;
      logic             do_blur;
      logic             blur_zero;
      logic [COL_W-1:0] blur_col;
      logic             do_out;
      logic             out_zero;
      logic             last;
   } token_type;

endpackage
`default_nettype wire

// ===== hdl/blur_then_sobel_magnitude_unit.sv =====
// Streaming 3x3 blur followed by 3x3 Sobel gradient magnitude on 8-bit grey pixels.
// Input channel req_*: one item per pixel in raster order (req_type pixel) or a
// flush tick; flush ticks sent before the whole frame has arrived are dropped.
// Result channel rsp_*: at most one item per accepted step; results trail the
// input stream by 2*width+2 steps, so 2*width+2 flush ticks drain the frame tail.
// last_of_frame marks the final result, after which a new frame starts.
// Config channel csr_*: index 0 row width in pixels, index 1 frame height in
// rows; a write to either restarts the frame. Write only while the block is idle.
// Timing: the front end takes an item per cycle into a two-entry queue while
// it is not full; the back end takes an item only when idle and steps it
// through shift, blur and sobel, plus gradient, square, bit-serial square root
// and emit if it yields a result, so the back end sequencer sets the sustained rate.
// Reset (synchronous, active high) restores 640x480, clears counters and
// windows; line buffers are not cleared and need no clearing pass.
// When rsp_ready is low the result is held in the output register; the back
// end stalls, then the queue fills and req_ready drops.
`default_nettype none
module blur_then_sobel_magnitude_unit import bsm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   token_type push_tok, head_tok;
   logic      push, full, pop, empty;

   // accept and classify
   bsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_push    (push),
      .q_token   (push_tok),
      .q_full    (full)
   );

   // decoupling queue
   bsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_tok),
      .full      (full),
      .pop       (pop),
      .head      (head_tok),
      .empty     (empty)
   );

   // line buffers, filters and output
   bsm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (head_tok),
      .q_empty   (empty),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hdl/bsm_front.sv =====
`default_nettype none
module bsm_front import bsm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type_type          req_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       q_push,
   output token_type                  q_token,
   input  wire logic                  q_full
);

   logic [WREG_W-1:0] width_ff;
   logic [HREG_W-1:0] height_ff;
   logic [COL_W-1:0]  in_col_ff, bx_ff, ox_ff;
   logic [ROW_W-1:0]  in_row_ff, by_ff, oy_ff;
   logic [LAG_W-1:0]  lag_ff;

   logic [WREG_W-1:0] eff_w, w_m1;
   logic [HREG_W-1:0] eff_h, h_m1;
   logic [LAG_W-1:0]  blur_start, out_start;
   logic              accept, input_done, step, blur_act, out_act, last;
   logic              cfg_wr;

   // clamp the frame size
   always_comb begin
      eff_w = width_ff;
      if (width_ff < WREG_W'(3)) eff_w = WREG_W'(3);
      if (width_ff > WREG_W'(MAX_WIDTH)) eff_w = WREG_W'(MAX_WIDTH);
      eff_h = height_ff;
      if (height_ff < HREG_W'(3)) eff_h = HREG_W'(3);
      if (height_ff > HREG_W'(MAX_HEIGHT)) eff_h = HREG_W'(MAX_HEIGHT);
   end

   assign w_m1       = eff_w - WREG_W'(1);
   assign h_m1       = eff_h - HREG_W'(1);
   assign blur_start = LAG_W'(eff_w) + LAG_W'(1);
   assign out_start  = LAG_W'({eff_w, 1'b0}) + LAG_W'(2);

   // classify the item
   assign req_ready  = !q_full;
   assign csr_ready  = 1'b1;
   assign cfg_wr     = csr_valid;
   assign accept     = req_valid && !q_full;
   assign input_done = (ROW_W'(in_row_ff) == ROW_W'(eff_h));
   assign step       = accept && !(req_data.req_type == REQ_FLUSH && !input_done);
   assign blur_act   = (lag_ff >= blur_start) && (ROW_W'(by_ff) != ROW_W'(eff_h));
   assign out_act    = (lag_ff >= out_start);
   assign last       = out_act && (WREG_W'(ox_ff) == w_m1) && (ROW_W'(oy_ff) == ROW_W'(h_m1));

   assign q_push = step;
   always_comb begin
      q_token.is_pix    = !input_done;
      q_token.pixel     = req_data.pixel;
      q_token.in_col    = in_col_ff;
      q_token.do_blur   = blur_act;
      q_token.blur_zero = (by_ff == '0) || (ROW_W'(by_ff) >= ROW_W'(h_m1))
                          || (bx_ff == '0) || (WREG_W'(bx_ff) >= w_m1);
      q_token.blur_col  = bx_ff;
      q_token.do_out    = out_act;
      q_token.out_zero  = (oy_ff == '0) || (ROW_W'(oy_ff) >= ROW_W'(h_m1))
                          || (ox_ff == '0) || (WREG_W'(ox_ff) >= w_m1);
      q_token.last      = last;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (cfg_wr) begin
         if (csr_index == CSR_FRAME_COLS) width_ff <= csr_wdata[WREG_W-1:0];
         if (csr_index == CSR_FRAME_ROWS) height_ff <= csr_wdata[HREG_W-1:0];
      end
   end

   // raster counters
   always_ff @(posedge clock) begin
      if (reset || (cfg_wr && (csr_index == CSR_FRAME_COLS
                               || csr_index == CSR_FRAME_ROWS))
          || (step && last)) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         bx_ff     <= '0;
         by_ff     <= '0;
         ox_ff     <= '0;
         oy_ff     <= '0;
         lag_ff    <= '0;
      end else if (step) begin
         if (!input_done) begin
            if (WREG_W'(in_col_ff) == w_m1) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + ROW_W'(1);
            end else begin
               in_col_ff <= in_col_ff + COL_W'(1);
            end
         end
         if (!out_act) lag_ff <= lag_ff + LAG_W'(1);
         if (blur_act) begin
            if (WREG_W'(bx_ff) == w_m1) begin
               bx_ff <= '0;
               by_ff <= by_ff + ROW_W'(1);
            end else begin
               bx_ff <= bx_ff + COL_W'(1);
            end
         end
         if (out_act) begin
            if (WREG_W'(ox_ff) == w_m1) begin
               ox_ff <= '0;
               oy_ff <= oy_ff + ROW_W'(1);
            end else begin
               ox_ff <= ox_ff + COL_W'(1);
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/bsm_queue.sv =====
`default_nettype none
module bsm_queue import bsm_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire token_type push_data,
   output logic           full,
   input  wire logic      pop,
   output token_type      head,
   output logic           empty
);

   token_type  slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // two-entry ring
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         if (do_push && !do_pop) count_ff <= count_ff + 2'd1;
         else if (do_pop && !do_push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/bsm_back.sv =====
`default_nettype none
module bsm_back import bsm_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire token_type q_head,
   input  wire logic      q_empty,
   output logic           q_pop,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_type        rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SHIFT  = 8'b0000_0010,
      ST_BLUR   = 8'b0000_0100,
      ST_SOBEL  = 8'b0000_1000,
      ST_GRAD   = 8'b0001_0000,
      ST_SQUARE = 8'b0010_0000,
      ST_ROOT   = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   token_type   tok_ff;
   logic [7:0]  iline1_ff [MAX_WIDTH];
   logic [7:0]  iline2_ff [MAX_WIDTH];
   logic [7:0]  bline1_ff [MAX_WIDTH];
   logic [7:0]  bline2_ff [MAX_WIDTH];
   logic [7:0]  ird1_ff, ird2_ff, brd1_ff, brd2_ff;
   logic [7:0]  iwin_ff [3][3];
   logic [7:0]  bwin_ff [3][3];
   logic [7:0]  blur_ff, gx_ff, gy_ff;
   logic [16:0] v_ff;
   logic [8:0]  root_ff;
   logic [3:0]  bit_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [10:0] bsum;
   logic [26:0] bprod;
   logic [8:0]  bquot;
   logic [7:0]  blur_val;
   logic [9:0]  gx_p, gx_n, gy_p, gy_n;
   logic [7:0]  gx_abs, gy_abs;
   logic [8:0]  trial;
   logic [17:0] trial_sq;
   logic        out_free;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // blur: cross kernel sum divided by six
   always_comb begin
      bsum = 11'(iwin_ff[1][0]) + 11'(iwin_ff[0][1]) + 11'({iwin_ff[1][1], 1'b0})
           + 11'(iwin_ff[2][1]) + 11'(iwin_ff[1][2]);
      bprod = 27'(bsum) * 27'(RECIP6);
      bquot = bprod[RECIP6_SHIFT+8:RECIP6_SHIFT];
      blur_val = (bquot > 9'd255) ? 8'd255 : bquot[7:0];
   end

   // sobel gradients, absolute value saturated
   always_comb begin
      gx_p = 10'(bwin_ff[0][2]) + 10'({bwin_ff[1][2], 1'b0}) + 10'(bwin_ff[2][2]);
      gx_n = 10'(bwin_ff[0][0]) + 10'({bwin_ff[1][0], 1'b0}) + 10'(bwin_ff[2][0]);
      gy_p = 10'(bwin_ff[2][0]) + 10'({bwin_ff[2][1], 1'b0}) + 10'(bwin_ff[2][2]);
      gy_n = 10'(bwin_ff[0][0]) + 10'({bwin_ff[0][1], 1'b0}) + 10'(bwin_ff[0][2]);
      if (gx_p >= gx_n) gx_abs = ((gx_p - gx_n) > 10'd255) ? 8'd255 : 8'(gx_p - gx_n);
      else gx_abs = ((gx_n - gx_p) > 10'd255) ? 8'd255 : 8'(gx_n - gx_p);
      if (gy_p >= gy_n) gy_abs = ((gy_p - gy_n) > 10'd255) ? 8'd255 : 8'(gy_p - gy_n);
      else gy_abs = ((gy_n - gy_p) > 10'd255) ? 8'd255 : 8'(gy_n - gy_p);
   end

   // one root bit per cycle
   assign trial    = root_ff | (9'd1 << bit_ff);
   assign trial_sq = 18'(trial) * 18'(trial);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (!q_empty) state_in = ST_SHIFT;
         ST_SHIFT:  state_in = ST_BLUR;
         ST_BLUR:   state_in = ST_SOBEL;
         ST_SOBEL:  state_in = tok_ff.do_out ? ST_GRAD : ST_IDLE;
         ST_GRAD:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ROOT;
         ST_ROOT:   if (bit_ff == 4'd0) state_in = ST_EMIT;
         ST_EMIT:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // input line buffers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ird1_ff <= iline1_ff[q_head.in_col];
         ird2_ff <= iline2_ff[q_head.in_col];
      end
      if (state_ff == ST_SHIFT && tok_ff.is_pix) begin
         iline1_ff[tok_ff.in_col] <= tok_ff.pixel;
         iline2_ff[tok_ff.in_col] <= ird1_ff;
      end
   end

   // blurred line buffers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         brd1_ff <= bline1_ff[q_head.blur_col];
         brd2_ff <= bline2_ff[q_head.blur_col];
      end
      if (state_ff == ST_SOBEL && tok_ff.do_blur) begin
         bline1_ff[tok_ff.blur_col] <= blur_ff;
         bline2_ff[tok_ff.blur_col] <= brd1_ff;
      end
   end

   // windows, newest column at index 2, rows oldest first
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               iwin_ff[c][r] <= 8'd0;
               bwin_ff[c][r] <= 8'd0;
            end
         end
      end else begin
         if (state_ff == ST_SHIFT && tok_ff.is_pix) begin
            iwin_ff[0] <= iwin_ff[1];
            iwin_ff[1] <= iwin_ff[2];
            iwin_ff[2][0] <= ird2_ff;
            iwin_ff[2][1] <= ird1_ff;
            iwin_ff[2][2] <= tok_ff.pixel;
         end
         if (state_ff == ST_SOBEL && tok_ff.do_blur) begin
            bwin_ff[0] <= bwin_ff[1];
            bwin_ff[1] <= bwin_ff[2];
            bwin_ff[2][0] <= brd2_ff;
            bwin_ff[2][1] <= brd1_ff;
            bwin_ff[2][2] <= blur_ff;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) tok_ff <= q_head;
      if (state_ff == ST_BLUR) begin
         blur_ff <= (tok_ff.do_blur && !tok_ff.blur_zero) ? blur_val : 8'd0;
      end
      if (state_ff == ST_GRAD) begin
         gx_ff <= gx_abs;
         gy_ff <= gy_abs;
      end
      if (state_ff == ST_SQUARE) begin
         v_ff    <= 17'(16'(gx_ff) * 16'(gx_ff)) + 17'(16'(gy_ff) * 16'(gy_ff));
         root_ff <= 9'd0;
         bit_ff  <= 4'd8;
      end
      if (state_ff == ST_ROOT) begin
         if (trial_sq <= 18'(v_ff)) root_ff <= trial;
         if (bit_ff != 4'd0) bit_ff <= bit_ff - 4'd1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && out_free) begin
         rsp_ff.magnitude     <= tok_ff.out_zero ? 8'd0
                                 : ((root_ff > 9'd255) ? 8'd255 : root_ff[7:0]);
         rsp_ff.last_of_frame <= tok_ff.last;
      end
   end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import bsm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 4'd9;
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam int RANDOM_ITEMS  = 1300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   blur_then_sobel_magnitude_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // magnitude model state
   logic [WREG_W-1:0] cfg_width;
   logic [HREG_W-1:0] cfg_height;
   logic [7:0] pix_rows [3][MAX_WIDTH];
   logic [7:0] blur_rows [3][MAX_WIDTH];
   int unsigned col_cnt, row_cnt, step_cnt, out_pos;

   rsp_type expected_results [$];
   int error_count = 0;
   int items_sent = 0;
   bit steady_stretch = 1'b0;
   int unsigned cycle_count = 0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned used_width();
      int unsigned w;
      w = cfg_width;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned used_height();
      int unsigned h;
      h = cfg_height;
      if (h < 3) h = 3;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   function automatic void restart_frame();
      col_cnt = 0;
      row_cnt = 0;
      step_cnt = 0;
      out_pos = 0;
   endfunction

   function automatic logic [7:0] blur_pixel(int unsigned y, int unsigned x,
                                             int unsigned w, int unsigned h);
      int unsigned s;
      if (y == 0 || y >= h - 1 || x == 0 || x >= w - 1) return 8'd0;
      s = pix_rows[(y - 1) % 3][x] + pix_rows[y % 3][x - 1] + 2 * pix_rows[y % 3][x]
        + pix_rows[y % 3][x + 1] + pix_rows[(y + 1) % 3][x];
      s = s / 6;
      if (s > 255) s = 255;
      return s[7:0];
   endfunction

   function automatic logic [7:0] edge_magnitude(int unsigned y, int unsigned x,
                                                 int unsigned w, int unsigned h);
      int gx, gy, u, m, d, r, sq;
      if (y == 0 || y >= h - 1 || x == 0 || x >= w - 1) return 8'd0;
      u = (y - 1) % 3;
      m = y % 3;
      d = (y + 1) % 3;
      gx = (int'(blur_rows[d][x - 1]) + 2 * int'(blur_rows[d][x]) + int'(blur_rows[d][x + 1]))
         - (int'(blur_rows[u][x - 1]) + 2 * int'(blur_rows[u][x]) + int'(blur_rows[u][x + 1]));
      gy = (int'(blur_rows[u][x + 1]) + 2 * int'(blur_rows[m][x + 1]) + int'(blur_rows[d][x + 1]))
         - (int'(blur_rows[u][x - 1]) + 2 * int'(blur_rows[m][x - 1]) + int'(blur_rows[d][x - 1]));
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      if (gx > 255) gx = 255;
      if (gy > 255) gy = 255;
      sq = gx * gx + gy * gy;
      r = 0;
      while ((r + 1) * (r + 1) <= sq) r++;
      if (r > 255) r = 255;
      return r[7:0];
   endfunction

   // advance the model by one accepted item
   function automatic void predict_step(req_type_type it);
      int unsigned w, h, total, s, b, o;
      rsp_type r;
      w = used_width();
      h = used_height();
      total = w * h;
      s = step_cnt;
      if (s < total) begin
         if (it.req_type == REQ_FLUSH) return;
         pix_rows[row_cnt % 3][col_cnt] = it.pixel;
         col_cnt++;
         if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
         end
      end
      if (s >= w + 1 && s - (w + 1) < total) begin
         b = s - (w + 1);
         blur_rows[(b / w) % 3][b % w] = blur_pixel(b / w, b % w, w, h);
      end
      step_cnt = s + 1;
      if (s >= 2 * w + 2) begin
         o = out_pos;
         r.magnitude = edge_magnitude(o / w, o % w, w, h);
         r.last_of_frame = (o == total - 1);
         expected_results.push_back(r);
         if (o == total - 1) restart_frame();
         else out_pos = o + 1;
      end
   endfunction

   function automatic void predict_config(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_FRAME_COLS) begin
         cfg_width = val[WREG_W-1:0];
         restart_frame();
      end else if (idx == CSR_FRAME_ROWS) begin
         cfg_height = val[HREG_W-1:0];
         restart_frame();
      end
   endfunction

   // one item on the input channel
   task automatic send_item(logic kind, logic [7:0] value);
      req_type_type it;
      if (!steady_stretch && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      it.req_type = kind;
      it.pixel = value;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      predict_step(it);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      predict_config(idx, val);
   endtask

   task automatic set_size(int unsigned w, int unsigned h);
      write_reg(CSR_FRAME_COLS, CSR_DATA_W'(w));
      write_reg(CSR_FRAME_ROWS, CSR_DATA_W'(h));
   endtask

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // pixels of a whole frame (mode 0 random, 1 fixed, 2 checkerboard) then the tail
   task automatic send_frame(int unsigned mode, logic [7:0] level, bit tail_pixels);
      int unsigned w, h;
      logic [7:0] v;
      w = used_width();
      h = used_height();
      for (int unsigned i = 0; i < w * h; i++) begin
         case (mode)
            0: v = pick_pixel();
            1: v = level;
            default: v = (((i / w) + (i % w)) % 2) ? 8'd255 : 8'd0;
         endcase
         send_item(REQ_PIXEL, v);
      end
      for (int unsigned i = 0; i < 2 * w + 2; i++) begin
         if (tail_pixels) send_item(REQ_PIXEL, 8'($urandom_range(255)));
         else send_item(REQ_FLUSH, 8'($urandom_range(255)));
      end
   endtask

   task automatic test_default_size();
      for (int i = 0; i < 10; i++) send_item(REQ_PIXEL, pick_pixel());
      send_item(REQ_FLUSH, 8'd0);
   endtask

   task automatic test_extreme_pixels();
      set_size(3, 3);
      send_frame(1, 8'd255, 1'b0);
      send_frame(1, 8'd0, 1'b0);
      set_size(5, 5);
      send_frame(2, 8'd0, 1'b0);
   endtask

   task automatic test_flush_rules();
      set_size(4, 3);
      send_item(REQ_FLUSH, 8'd255);
      send_item(REQ_FLUSH, 8'd0);
      send_frame(0, 8'd0, 1'b1);
   endtask

   task automatic test_clamped_sizes();
      set_size(0, 2);
      send_frame(0, 8'd0, 1'b0);
      // widest frame: nothing comes out before the lag has passed
      set_size(2047, 8191);
      for (int i = 0; i < 40; i++) send_item(REQ_PIXEL, pick_pixel());
   endtask

   task automatic test_steady_stretch();
      set_size(12, 7);
      steady_stretch = 1'b1;
      send_frame(0, 8'd0, 1'b0);
      steady_stretch = 1'b0;
   endtask

   task automatic test_unknown_index_and_abort();
      set_size(6, 4);
      for (int i = 0; i < 5; i++) send_item(REQ_PIXEL, pick_pixel());
      // unused index leaves the frame running
      write_reg(CSR_UNUSED_INDEX, 13'h1fff);
      for (int i = 5; i < 24; i++) send_item(REQ_PIXEL, pick_pixel());
      for (int i = 0; i < 14; i++) send_item(REQ_FLUSH, 8'd0);
      // a real write mid frame restarts it
      for (int i = 0; i < 7; i++) send_item(REQ_PIXEL, pick_pixel());
      write_reg(CSR_FRAME_COLS, CSR_DATA_W'(6));
      send_frame(0, 8'd0, 1'b0);
   endtask

   task automatic test_random_frames();
      int unsigned w, h, n;
      int start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(3) == 0) set_size($urandom_range(12, 3), $urandom_range(7, 3));
         else if ($urandom_range(1))
            write_reg(CSR_FRAME_COLS, CSR_DATA_W'($urandom_range(10, 3)));
         steady_stretch = ($urandom_range(5) == 0);
         w = used_width();
         h = used_height();
         n = 0;
         while (n < w * h) begin
            if ($urandom_range(15) == 0) send_item(REQ_FLUSH, 8'($urandom_range(255)));
            else begin
               send_item(REQ_PIXEL, pick_pixel());
               n++;
            end
         end
         for (int unsigned i = 0; i < 2 * w + 2; i++)
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
         if ($urandom_range(7) == 0)
            for (int i = 0; i < 3; i++) send_item(REQ_PIXEL, pick_pixel());
      end
      steady_stretch = 1'b0;
   endtask

   // result ready with random stalls, held high during a steady stretch
   always @(posedge clock) begin
      if (steady_stretch) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 9);
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result magnitude=%0d last_of_frame=%0d",
                   rsp_data.magnitude, rsp_data.last_of_frame);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.magnitude !== want.magnitude) begin
               $error("magnitude expected %0d actual %0d", want.magnitude, rsp_data.magnitude);
               error_count++;
            end
            if (rsp_data.last_of_frame !== want.last_of_frame) begin
               $error("last_of_frame expected %0d actual %0d",
                      want.last_of_frame, rsp_data.last_of_frame);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      cfg_width = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      restart_frame();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_size();
      test_extreme_pixels();
      test_flush_rules();
      test_clamped_sizes();
      test_steady_stretch();
      test_unknown_index_and_abort();
      test_random_frames();
      wait_drained();
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
